### hw/rtl/des_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg
// DES tables, permutations and round function shared by the key schedule and the block engine
// ----------------------------------------------------------------------------
package des_pkg;

  typedef enum logic [1:0] {
    CFG_KEY  = 2'd0,
    CFG_IV   = 2'd1,
    CFG_MODE = 2'd2,
    CFG_DIR  = 2'd3
  } cfg_idx_e;

  localparam int unsigned BlockBytes = 8;

  typedef logic [63:0] blk_t;
  typedef logic [47:0] subkey_t;
  typedef subkey_t [15:0] sched_t;

  localparam logic [7:0] TabIp [64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam logic [7:0] TabFp [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam logic [7:0] TabE [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam logic [7:0] TabP [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam logic [7:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};
  localparam logic [7:0] TabPc2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
    logic [27:0] r;
    r = (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TabE[i])];
    e = e ^ k;
    for (int i = 0; i < 8; i++) begin
      six = e[42-6*i +: 6];
      o[28-4*i +: 4] = TabS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32-int'(TabP[i])];
    return p;
  endfunction

endpackage

### hw/rtl/des_key_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_key_sched
// registered sixteen-entry subkey schedule, rebuilt when the key is written
// ----------------------------------------------------------------------------
module des_key_sched (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             key_we_i,
  input  logic [63:0]      key_i,
  output des_pkg::sched_t  sched_o
);

  des_pkg::sched_t sched_d, sched_q;
  logic [55:0] cd;
  logic [27:0] c, d;

  always_comb begin
    cd = des_pkg::perm_pc1(key_i);
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      c = des_pkg::rot28(c, des_pkg::TabRot[i]);
      d = des_pkg::rot28(d, des_pkg::TabRot[i]);
      sched_d[i] = des_pkg::perm_pc2({c, d});
    end
  end

  // reset key is zero, whose schedule is all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_q <= '0;
    end else if (key_we_i) begin
      sched_q <= sched_d;
    end
  end

  assign sched_o = sched_q;

endmodule

### hw/rtl/des_ecb_cbc_block_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_ecb_cbc_block_engine_unit
// DES encrypt or decrypt in ECB or CBC mode, one 64-bit block per transfer
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the input transfer
// throughput: one block per cycle while the output is not stalled; all sixteen rounds are
//   combinational so the CBC chain closes before the next block
// reset: key, IV, mode, direction and chain clear to zero, no result pending
module des_ecb_cbc_block_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_in_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        first_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] block_out_o,
  output logic        short_block_error_o
);

  logic [63:0] iv_q, chain_q, chain_d;
  logic        cbc_q, dec_q;
  logic        out_valid_q;
  logic [63:0] res_q, res_d;
  logic        err_q, err_d;
  logic        in_xfer, cfg_xfer;
  des_pkg::sched_t sched;

  logic [63:0] mask, pre, x, core, cur_chain;
  logic [31:0] l, r, t;
  logic [3:0]  vb;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  des_key_sched u_sched (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_we_i(cfg_xfer && (cfg_index_i == des_pkg::CFG_KEY)),
    .key_i   (cfg_data_i),
    .sched_o (sched)
  );

  always_comb begin
    cur_chain = first_block_i ? iv_q : chain_q;
    vb = (valid_bytes_i > 4'(des_pkg::BlockBytes)) ? 4'(des_pkg::BlockBytes)
                                                  : valid_bytes_i;
    for (int i = 0; i < 8; i++) mask[63-8*i -: 8] = (4'(i) < vb) ? 8'hff : 8'h00;
    pre = dec_q ? block_in_i : ((block_in_i & mask) ^ (cbc_q ? cur_chain : '0));
    x = des_pkg::perm_ip(pre);
    l = x[63:32];
    r = x[31:0];
    for (int i = 0; i < 16; i++) begin
      t = r;
      r = l ^ des_pkg::feistel(r, dec_q ? sched[15-i] : sched[i]);
      l = t;
    end
    core = des_pkg::perm_fp({r, l});
    chain_d = cur_chain;
    err_d = 1'b0;
    if (dec_q) begin
      if (vb != 4'(des_pkg::BlockBytes)) begin
        res_d = '0;
        err_d = 1'b1;
      end else begin
        res_d = cbc_q ? (core ^ cur_chain) : core;
        if (cbc_q) chain_d = block_in_i;
      end
    end else begin
      res_d = core;
      if (cbc_q) chain_d = core;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q        <= '0;
      cbc_q       <= 1'b0;
      dec_q       <= 1'b0;
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        unique case (des_pkg::cfg_idx_e'(cfg_index_i))
          des_pkg::CFG_KEY:  ;
          des_pkg::CFG_IV:   iv_q  <= cfg_data_i;
          des_pkg::CFG_MODE: cbc_q <= cfg_data_i[0];
          des_pkg::CFG_DIR:  dec_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        chain_q     <= chain_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
      err_q <= err_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign block_out_o         = res_q;
  assign short_block_error_o = err_q;

endmodule
